/* hdl/mtc_pkg.sv */
`default_nettype none
package mtc_pkg;

    // Default number of fraction bits in the result fields.
    localparam int OUT_FRAC_BITS_DEF = 8;

    // Quotient bits produced by the divider pipelines.
    localparam int Q_W = 24;
    // Divisor widths: r*r for X and Y, |D| for Z.
    localparam int RR_W = 28;
    localparam int DZ_W = 31;
    // Magnitude widths of the numerators before scaling.
    localparam int NUMX_MAG_W = 61;
    localparam int NUMZ_MAG_W = 43;
    // The X and Y denominator carries a factor of 2^17.
    localparam int XY_DEN_SHIFT = 17;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TRIM_XY   = 3'd0;
    localparam logic [2:0] CFG_TRIM_Z1   = 3'd1;
    localparam logic [2:0] CFG_TRIM_Z2   = 3'd2;
    localparam logic [2:0] CFG_TRIM_Z3   = 3'd3;
    localparam logic [2:0] CFG_TRIM_Z4   = 3'd4;
    localparam logic [2:0] CFG_TRIM_XYZ1 = 3'd5;

    // Overflow codes of the raw axis values.
    localparam logic signed [12:0] MXY_OVF = -13'sd4096;
    localparam logic signed [14:0] MZ_OVF  = -15'sd16384;

    // Output saturation limits.
    localparam logic [23:0] FIELD_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] FIELD_NEG_MAX = 24'h800000;

    typedef struct packed {
        logic signed [7:0]  x1;
        logic signed [7:0]  y1;
        logic signed [7:0]  x2;
        logic signed [7:0]  y2;
        logic signed [7:0]  xy2;
        logic [7:0]         xy1;
        logic [15:0]        z1;
        logic signed [15:0] z2;
        logic signed [15:0] z3;
        logic signed [15:0] z4;
        logic [14:0]        xyz1;
    } t_trim;

    typedef struct packed {
        logic signed [12:0] mx;
        logic signed [12:0] my;
        logic signed [14:0] mz;
        logic [13:0]        r;
        logic               vx;
        logic               vy;
        logic               vz;
    } t_item;

    // Turn a quotient magnitude into a signed, saturated field.
    function automatic logic [23:0] sat_field(input logic [Q_W-1:0] q, input logic ovf,
                                              input logic neg, input logic ok);
        logic [Q_W:0] mag;
        logic [23:0]  res;
        mag = ovf ? {1'b1, {Q_W{1'b0}}} : {1'b0, q};
        if (!ok) begin
            res = 24'd0;
        end else if (neg) begin
            res = (mag >= (Q_W+1)'(FIELD_NEG_MAX)) ? FIELD_NEG_MAX : 24'(-mag);
        end else begin
            res = (mag > (Q_W+1)'(FIELD_POS_MAX)) ? FIELD_POS_MAX : mag[23:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* hdl/mtc_front.sv */
`default_nettype none
module mtc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    input  wire logic [63:0]   i_s_tdata,
    output mtc_pkg::t_trim     o_trim,
    output mtc_pkg::t_item     o_item
);
    import mtc_pkg::*;

    logic [47:0] r_trim_xy;
    logic [15:0] r_trim_z1;
    logic [15:0] r_trim_z2;
    logic [15:0] r_trim_z3;
    logic [15:0] r_trim_z4;
    logic [14:0] r_trim_xyz1;

    // Trim registers, to be written by the user only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_xy   <= '0;
            r_trim_z1   <= '0;
            r_trim_z2   <= '0;
            r_trim_z3   <= '0;
            r_trim_z4   <= '0;
            r_trim_xyz1 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIM_XY:   r_trim_xy   <= i_cfg_data;
                CFG_TRIM_Z1:   r_trim_z1   <= i_cfg_data[15:0];
                CFG_TRIM_Z2:   r_trim_z2   <= i_cfg_data[15:0];
                CFG_TRIM_Z3:   r_trim_z3   <= i_cfg_data[15:0];
                CFG_TRIM_Z4:   r_trim_z4   <= i_cfg_data[15:0];
                CFG_TRIM_XYZ1: r_trim_xyz1 <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Split the packed trim bytes.
    always_comb begin
        o_trim.x1   = r_trim_xy[7:0];
        o_trim.y1   = r_trim_xy[15:8];
        o_trim.x2   = r_trim_xy[23:16];
        o_trim.y2   = r_trim_xy[31:24];
        o_trim.xy2  = r_trim_xy[39:32];
        o_trim.xy1  = r_trim_xy[47:40];
        o_trim.z1   = r_trim_z1;
        o_trim.z2   = r_trim_z2;
        o_trim.z3   = r_trim_z3;
        o_trim.z4   = r_trim_z4;
        o_trim.xyz1 = r_trim_xyz1;
    end

    logic signed [15:0] w_sx;
    logic signed [15:0] w_sy;
    logic signed [15:0] w_tx;
    logic signed [15:0] w_ty;
    logic               w_trim_ok;

    // Unpack the raw words and classify each axis.
    always_comb begin
        w_sx = {i_s_tdata[15:1], 1'b0};
        w_sy = {i_s_tdata[31:17], 1'b0};
        // Division by eight rounds toward zero.
        w_tx = w_sx + (w_sx[15] ? 16'sd7 : 16'sd0);
        w_ty = w_sy + (w_sy[15] ? 16'sd7 : 16'sd0);
        o_item.mx = w_tx[15:3];
        o_item.my = w_ty[15:3];
        o_item.mz = i_s_tdata[47:33];
        o_item.r  = i_s_tdata[63:50];
        w_trim_ok = (o_item.r != '0) && (r_trim_xyz1 != '0);
        o_item.vx = w_trim_ok && (o_item.mx != MXY_OVF);
        o_item.vy = w_trim_ok && (o_item.my != MXY_OVF);
        o_item.vz = w_trim_ok && (o_item.mz != MZ_OVF) && (r_trim_z1 != '0)
                    && (r_trim_z2 != '0);
    end

endmodule
`default_nettype wire

/* hdl/mtc_queue.sv */
`default_nettype none
module mtc_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire mtc_pkg::t_item i_item,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_vld,
    output mtc_pkg::t_item o_item
);
    import mtc_pkg::*;

    t_item           r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/mtc_divider.sv */
`default_nettype none
module mtc_divider #(
    parameter int NW = 52,
    parameter int DW = 28,
    parameter int QW = 24,
    parameter int SW = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_a,
    input  wire logic [DW-1:0] i_b,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_q,
    output logic               o_ovf,
    output logic [SW-1:0]      o_side
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]   r_vld;
    logic [QW:0]   r_ovf;
    logic [QW-1:0] r_q    [0:QW];
    logic [SW-1:0] r_side [0:QW];
    logic [DW-1:0] r_rem  [0:QW-1];
    logic [DW-1:0] r_b    [0:QW-1];
    logic [QW-1:0] r_low  [0:QW-1];

    logic [CW-1:0] w_hi;
    logic          w_ovf;

    // The quotient needs more than QW bits when the top part reaches the divisor.
    assign w_hi  = CW'(i_a >> QW);
    assign w_ovf = (w_hi >= CW'(i_b));

    // Valid bits move with the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    // Entry stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= w_ovf;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
            r_rem[0]  <= w_hi[DW-1:0];
            r_b[0]    <= i_b;
            r_low[0]  <= i_a[QW-1:0];
        end
    end

    // One quotient bit per stage, restoring.
    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [DW:0]   w_diff;

        always_comb begin
            w_trial = {r_rem[i], r_low[i][QW-1]};
            w_ge    = (w_trial >= {1'b0, r_b[i]});
            w_diff  = w_ge ? (w_trial - {1'b0, r_b[i]}) : w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[i+1]  <= r_ovf[i];
                r_q[i+1]    <= {r_q[i][QW-2:0], w_ge};
                r_side[i+1] <= r_side[i];
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i+1] <= w_diff[DW-1:0];
                    r_b[i+1]   <= r_b[i];
                    r_low[i+1] <= {r_low[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_q    = r_q[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_side = r_side[QW];

endmodule
`default_nettype wire

/* hdl/mtc_back.sv */
`default_nettype none
module mtc_back #(
    parameter int OUT_FRAC_BITS = mtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire mtc_pkg::t_trim i_trim,
    input  wire logic      i_q_vld,
    input  wire mtc_pkg::t_item i_item,
    output logic           o_pop,
    input  wire logic      i_ready,
    output logic           o_vld,
    output logic [23:0]    o_x,
    output logic [23:0]    o_y,
    output logic [23:0]    o_z,
    output logic           o_vx,
    output logic           o_vy,
    output logic           o_vz
);
    import mtc_pkg::*;

    localparam int NWX = NUMX_MAG_W - XY_DEN_SHIFT + OUT_FRAC_BITS;
    localparam int NWZ = NUMZ_MAG_W + OUT_FRAC_BITS;
    localparam int XSH = XY_DEN_SHIFT - OUT_FRAC_BITS;

    logic w_en;
    logic w_dvx;
    logic w_dvy;
    logic w_dvz;

    // The whole pipeline holds while a finished result waits.
    assign w_en  = !o_vld || i_ready;
    assign o_pop = w_en && i_q_vld;
    assign o_vld = w_dvx && w_dvy && w_dvz;

    logic [4:1] r_vld;

    // Stage 1: squares, cross term and axis gains.
    logic [27:0]        r1_rr;
    logic signed [30:0] r1_dd;
    logic signed [29:0] r1_dr;
    logic signed [22:0] r1_kx;
    logic signed [22:0] r1_ky;
    logic signed [16:0] r1_mz4;
    logic signed [15:0] r1_rx;
    logic [29:0]        r1_z1r;
    logic [2:0]         r1_ok;

    logic signed [14:0] w_r;
    logic signed [15:0] w_xyz1;
    logic signed [16:0] w_d;
    logic signed [9:0]  w_cx;
    logic signed [9:0]  w_cy;
    logic [27:0]        n1_rr;
    logic signed [30:0] n1_dd;
    logic signed [29:0] n1_dr;
    logic signed [22:0] n1_kx;
    logic signed [22:0] n1_ky;
    logic signed [16:0] n1_mz4;
    logic signed [15:0] n1_rx;
    logic [29:0]        n1_z1r;

    always_comb begin
        w_r    = {1'b0, i_item.r};
        w_xyz1 = {1'b0, i_trim.xyz1};
        w_d    = w_xyz1 - w_r;
        w_cx   = i_trim.x2 + 10'sd160;
        w_cy   = i_trim.y2 + 10'sd160;
        n1_rr  = i_item.r * i_item.r;
        n1_dd  = w_d * w_d;
        n1_dr  = w_d * w_r;
        n1_kx  = i_item.mx * w_cx;
        n1_ky  = i_item.my * w_cy;
        n1_mz4 = i_item.mz - i_trim.z4;
        n1_rx  = w_r - w_xyz1;
        n1_z1r = i_trim.z1 * i_item.r;
    end

    // Stage 2: hall ratio polynomial and Z denominator.
    logic signed [39:0] r2_nn;
    logic signed [22:0] r2_kx;
    logic signed [22:0] r2_ky;
    logic signed [36:0] r2_x1rr;
    logic signed [36:0] r2_y1rr;
    logic [27:0]        r2_rr;
    logic signed [16:0] r2_mz4;
    logic signed [31:0] r2_z3rx;
    logic signed [32:0] r2_d;
    logic [2:0]         r2_ok;

    logic signed [8:0]  w_xy1;
    logic signed [28:0] w_rr;
    logic signed [32:0] w_z1r;
    logic signed [39:0] n2_nn;
    logic signed [36:0] n2_x1rr;
    logic signed [36:0] n2_y1rr;
    logic signed [31:0] n2_z3rx;
    logic signed [32:0] n2_d;

    always_comb begin
        w_xy1   = {1'b0, i_trim.xy1};
        w_rr    = {1'b0, r1_rr};
        w_z1r   = {3'b000, r1_z1r};
        n2_nn   = i_trim.xy2 * r1_dd + w_xy1 * r1_dr + (w_rr <<< 8);
        n2_x1rr = i_trim.x1 * w_rr;
        n2_y1rr = i_trim.y1 * w_rr;
        n2_z3rx = i_trim.z3 * r1_rx;
        n2_d    = (i_trim.z2 <<< 15) + w_z1r;
    end

    // Stage 3: gain times polynomial in two halves, Z numerator.
    logic signed [43:0] r3_xlo;
    logic signed [42:0] r3_xhi;
    logic signed [43:0] r3_ylo;
    logic signed [42:0] r3_yhi;
    logic signed [36:0] r3_x1rr;
    logic signed [36:0] r3_y1rr;
    logic [27:0]        r3_rr;
    logic signed [43:0] r3_numz;
    logic signed [32:0] r3_d;
    logic [2:0]         r3_ok;

    logic signed [20:0] w_nlo;
    logic signed [19:0] w_nhi;
    logic signed [43:0] n3_xlo;
    logic signed [42:0] n3_xhi;
    logic signed [43:0] n3_ylo;
    logic signed [42:0] n3_yhi;
    logic signed [43:0] n3_numz;

    always_comb begin
        w_nlo   = {1'b0, r2_nn[19:0]};
        w_nhi   = r2_nn[39:20];
        n3_xlo  = r2_kx * w_nlo;
        n3_xhi  = r2_kx * w_nhi;
        n3_ylo  = r2_ky * w_nlo;
        n3_yhi  = r2_ky * w_nhi;
        n3_numz = ((r2_mz4 <<< 17) - r2_z3rx) <<< 9;
    end

    // Stage 4: full X and Y numerators.
    logic signed [61:0] r4_numx;
    logic signed [61:0] r4_numy;
    logic [27:0]        r4_rr;
    logic signed [43:0] r4_numz;
    logic signed [32:0] r4_d;
    logic [2:0]         r4_ok;

    logic signed [61:0] n4_numx;
    logic signed [61:0] n4_numy;

    always_comb begin
        n4_numx = (r3_xhi <<< 20) + r3_xlo + (r3_x1rr <<< 16);
        n4_numy = (r3_yhi <<< 20) + r3_ylo + (r3_y1rr <<< 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:1], o_pop};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rr   <= n1_rr;
            r1_dd   <= n1_dd;
            r1_dr   <= n1_dr;
            r1_kx   <= n1_kx;
            r1_ky   <= n1_ky;
            r1_mz4  <= n1_mz4;
            r1_rx   <= n1_rx;
            r1_z1r  <= n1_z1r;
            r1_ok   <= {i_item.vz, i_item.vy, i_item.vx};

            r2_nn   <= n2_nn;
            r2_kx   <= r1_kx;
            r2_ky   <= r1_ky;
            r2_x1rr <= n2_x1rr;
            r2_y1rr <= n2_y1rr;
            r2_rr   <= r1_rr;
            r2_mz4  <= r1_mz4;
            r2_z3rx <= n2_z3rx;
            r2_d    <= n2_d;
            r2_ok   <= r1_ok;

            r3_xlo  <= n3_xlo;
            r3_xhi  <= n3_xhi;
            r3_ylo  <= n3_ylo;
            r3_yhi  <= n3_yhi;
            r3_x1rr <= r2_x1rr;
            r3_y1rr <= r2_y1rr;
            r3_rr   <= r2_rr;
            r3_numz <= n3_numz;
            r3_d    <= r2_d;
            // A zero Z denominator drops the Z axis.
            r3_ok   <= {r2_ok[2] && (r2_d != '0), r2_ok[1:0]};

            r4_numx <= n4_numx;
            r4_numy <= n4_numy;
            r4_rr   <= r3_rr;
            r4_numz <= r3_numz;
            r4_d    <= r3_d;
            r4_ok   <= r3_ok;
        end
    end

    // Magnitudes and signs for the dividers.
    logic                  w_negx;
    logic                  w_negy;
    logic                  w_negz;
    logic [NUMX_MAG_W-1:0] w_anx;
    logic [NUMX_MAG_W-1:0] w_any;
    logic [NUMZ_MAG_W-1:0] w_anz;
    logic [DZ_W-1:0]       w_adz;
    logic [NWX-1:0]        w_ax;
    logic [NWX-1:0]        w_ay;
    logic [NWZ-1:0]        w_az;

    always_comb begin
        w_negx = r4_numx[61];
        w_negy = r4_numy[61];
        w_negz = r4_numz[43] ^ r4_d[32];
        w_anx  = w_negx ? NUMX_MAG_W'(-r4_numx) : r4_numx[NUMX_MAG_W-1:0];
        w_any  = w_negy ? NUMX_MAG_W'(-r4_numy) : r4_numy[NUMX_MAG_W-1:0];
        w_anz  = r4_numz[43] ? NUMZ_MAG_W'(-r4_numz) : r4_numz[NUMZ_MAG_W-1:0];
        w_adz  = r4_d[32] ? DZ_W'(-r4_d) : r4_d[DZ_W-1:0];
        // The 2^17 of the X and Y denominator folds into the scaling.
        w_ax   = NWX'(w_anx >> XSH);
        w_ay   = NWX'(w_any >> XSH);
        w_az   = {w_anz, {OUT_FRAC_BITS{1'b0}}};
    end

    logic [Q_W-1:0] w_qx;
    logic [Q_W-1:0] w_qy;
    logic [Q_W-1:0] w_qz;
    logic           w_ovx;
    logic           w_ovy;
    logic           w_ovz;
    logic [1:0]     w_sx;
    logic [1:0]     w_sy;
    logic [1:0]     w_sz;

    mtc_divider #(.NW(NWX), .DW(RR_W), .QW(Q_W), .SW(2)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vld[4]),
        .i_a    (w_ax),
        .i_b    (r4_rr),
        .i_side ({w_negx, r4_ok[0]}),
        .o_vld  (w_dvx),
        .o_q    (w_qx),
        .o_ovf  (w_ovx),
        .o_side (w_sx)
    );

    mtc_divider #(.NW(NWX), .DW(RR_W), .QW(Q_W), .SW(2)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vld[4]),
        .i_a    (w_ay),
        .i_b    (r4_rr),
        .i_side ({w_negy, r4_ok[1]}),
        .o_vld  (w_dvy),
        .o_q    (w_qy),
        .o_ovf  (w_ovy),
        .o_side (w_sy)
    );

    mtc_divider #(.NW(NWZ), .DW(DZ_W), .QW(Q_W), .SW(2)) u_div_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vld[4]),
        .i_a    (w_az),
        .i_b    (w_adz),
        .i_side ({w_negz, r4_ok[2]}),
        .o_vld  (w_dvz),
        .o_q    (w_qz),
        .o_ovf  (w_ovz),
        .o_side (w_sz)
    );

    // Sign, saturation and the invalid-axis zero.
    assign o_x  = sat_field(w_qx, w_ovx, w_sx[1], w_sx[0]);
    assign o_y  = sat_field(w_qy, w_ovy, w_sy[1], w_sy[0]);
    assign o_z  = sat_field(w_qz, w_ovz, w_sz[1], w_sz[0]);
    assign o_vx = w_sx[0];
    assign o_vy = w_sy[0];
    assign o_vz = w_sz[0];

endmodule
`default_nettype wire

/* hdl/magnetometer_trim_compensation_unit.sv */
`default_nettype none
// Three-axis magnetometer trim compensation. Each input transfer carries one raw
// burst (X, Y, Z and hall words); each output transfer carries compensated X, Y
// and Z in signed microtesla with OUT_FRAC_BITS fraction bits, truncated toward
// zero and saturated to 24 bits, plus a valid flag per axis (an invalid axis
// reads zero). A four-entry queue sits between the input classifier and the
// datapath; one burst is accepted every cycle while the queue is not full. A
// burst passes through the queue, four multiply stages and the restoring
// divider, which produces one quotient bit per stage. The user must see that trim
// registers are written through the configuration channel only while no burst is
// in flight; the block does not enforce this, and the channel is always ready.
module magnetometer_trim_compensation_unit #(
    parameter int OUT_FRAC_BITS = mtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // x_word, y_word, z_word, hall_word
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // x_field, y_field, z_field
    output logic [2:0]       o_m_tuser    // x_valid, y_valid, z_valid
);
    import mtc_pkg::*;

    t_trim w_trim;
    t_item w_item;
    t_item w_head;
    logic  w_full;
    logic  w_push;
    logic  w_pop;
    logic  w_head_vld;
    logic [23:0] w_x;
    logic [23:0] w_y;
    logic [23:0] w_z;
    logic  w_vx;
    logic  w_vy;
    logic  w_vz;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;
    assign w_push      = i_s_tvalid && !w_full;

    mtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .o_trim     (w_trim),
        .o_item     (w_item)
    );

    mtc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_item),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_vld  (w_head_vld),
        .o_item (w_head)
    );

    mtc_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_trim (w_trim),
        .i_q_vld(w_head_vld),
        .i_item (w_head),
        .o_pop  (w_pop),
        .i_ready(i_m_tready),
        .o_vld  (o_m_tvalid),
        .o_x    (w_x),
        .o_y    (w_y),
        .o_z    (w_z),
        .o_vx   (w_vx),
        .o_vy   (w_vy),
        .o_vz   (w_vz)
    );

    assign o_m_tdata = {w_z, w_y, w_x};
    assign o_m_tuser = {w_vz, w_vy, w_vx};

endmodule
`default_nettype wire

/* test/magnetometer_trim_compensation_unit_tb.sv */
`timescale 1ns / 1ps
module magnetometer_trim_compensation_unit_tb;
    import mtc_pkg::*;

    localparam int FRAC = 8;
    localparam int SETTLE = 48;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_TRIM_XY;
    logic [47:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    magnetometer_trim_compensation_unit #(.OUT_FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Trim copy used by the predictor.
    logic [47:0] trim_xy;
    logic [15:0] trim_z1, trim_z2, trim_z3, trim_z4;
    logic [14:0] trim_xyz1;

    // Expected field words: {z_valid, y_valid, x_valid, z, y, x}.
    logic [74:0] field_q[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    // Truncating scaled division with 24-bit saturation.
    function automatic logic [23:0] scale_div(longint num, longint den);
        bit neg;
        longint unsigned an, ad, q, v;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? longint'(-num) : num;
        ad = (den < 0) ? longint'(-den) : den;
        q = an / ad;
        if (q >= 64'd16777216) v = 64'd8388608;
        else v = (q << FRAC) + (((an % ad) << FRAC) / ad);
        if (neg) begin
            if (v > 64'd8388608) v = 64'd8388608;
            return 24'(-longint'(v));
        end
        if (v > 64'd8388607) v = 64'd8388607;
        return 24'(v);
    endfunction

    function automatic void xy_axis(longint m, longint r, longint c1, longint c2,
                                    output logic [23:0] f, output logic ok);
        longint xy1, xy2, xyz1, d, n;
        xy2 = longint'($signed(trim_xy[39:32]));
        xy1 = longint'(trim_xy[47:40]);
        xyz1 = longint'(trim_xyz1);
        ok = (m != -4096) && (r != 0) && (xyz1 != 0);
        f = '0;
        if (ok) begin
            d = xyz1 - r;
            n = xy2 * d * d + xy1 * d * r + 256 * r * r;
            f = scale_div(m * (c2 + 160) * n + c1 * 65536 * r * r, 131072 * r * r);
        end
    endfunction

    function automatic logic [74:0] predict_fields(logic [15:0] xw, yw, zw, hw);
        longint mx, my, mz, r, z1, z2, z3, z4, xyz1, den;
        logic [23:0] fx, fy, fz;
        logic vx, vy, vz;
        mx = longint'($signed(xw & 16'hFFFE)) / 8;
        my = longint'($signed(yw & 16'hFFFE)) / 8;
        mz = longint'($signed(zw & 16'hFFFE)) / 2;
        r = longint'(hw >> 2);
        xy_axis(mx, r, longint'($signed(trim_xy[7:0])), longint'($signed(trim_xy[23:16])),
                fx, vx);
        xy_axis(my, r, longint'($signed(trim_xy[15:8])), longint'($signed(trim_xy[31:24])),
                fy, vy);
        z1 = longint'(trim_z1);
        z2 = longint'($signed(trim_z2));
        z3 = longint'($signed(trim_z3));
        z4 = longint'($signed(trim_z4));
        xyz1 = longint'(trim_xyz1);
        vz = (mz != -16384) && (z1 != 0) && (z2 != 0) && (xyz1 != 0) && (r != 0);
        fz = '0;
        if (vz) begin
            den = z2 * 32768 + z1 * r;
            if (den == 0) vz = 1'b0;
            else fz = scale_div(((mz - z4) * 131072 - z3 * (r - xyz1)) * 512, den);
        end
        return {vz, vy, vx, fz, fy, fx};
    endfunction

    // One configuration transfer.
    task automatic write_trim(logic [2:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TRIM_XY:   trim_xy = data;
            CFG_TRIM_Z1:   trim_z1 = data[15:0];
            CFG_TRIM_Z2:   trim_z2 = data[15:0];
            CFG_TRIM_Z3:   trim_z3 = data[15:0];
            CFG_TRIM_Z4:   trim_z4 = data[15:0];
            CFG_TRIM_XYZ1: trim_xyz1 = data[14:0];
            default: ;
        endcase
    endtask

    task automatic load_trims(logic [47:0] xy, logic [15:0] z1, z2, z3, z4,
                              logic [14:0] xyz1);
        write_trim(CFG_TRIM_XY, xy);
        write_trim(CFG_TRIM_Z1, {32'd0, z1});
        write_trim(CFG_TRIM_Z2, {32'd0, z2});
        write_trim(CFG_TRIM_Z3, {32'd0, z3});
        write_trim(CFG_TRIM_Z4, {32'd0, z4});
        write_trim(CFG_TRIM_XYZ1, {33'd0, xyz1});
    endtask

    // Wait for all results, then for the pipeline to settle.
    task automatic drain_results();
        while (field_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One input transfer; the expectation is typed in or predicted.
    task automatic send_burst(logic [15:0] xw, yw, zw, hw, bit typed, logic [74:0] want);
        if (!quiet && $urandom_range(99) < 6) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {hw, zw, yw, xw};
        do @(posedge i_clk); while (!o_s_tready);
        field_q.push_back(typed ? want : predict_fields(xw, yw, zw, hw));
    endtask

    // Trim sets: 0 realistic, 1 fully random, 2 upper extremes, 3 lower extremes.
    task automatic random_trims(int kind);
        case (kind)
            0: load_trims({8'($urandom_range(20, 40)), 8'(-$urandom_range(0, 8)),
                           8'($urandom_range(20, 30)), 8'($urandom_range(20, 30)),
                           8'($signed($urandom_range(0, 20)) - 10),
                           8'($signed($urandom_range(0, 20)) - 10)},
                          16'($urandom_range(20000, 30000)), 16'($urandom_range(500, 1000)),
                          16'($signed($urandom_range(0, 200)) - 100), 16'($urandom_range(0, 20)),
                          15'($urandom_range(6000, 8000)));
            1: load_trims({$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 15'($urandom));
            2: load_trims({8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F}, 16'hFFFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF, 15'h7FFF);
            default: load_trims({8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 16'h0001,
                                16'h8000, 16'h8000, 16'h8000, 15'h0001);
        endcase
    endtask

    task automatic random_bursts(int count, bool_near);
        logic [15:0] hw;
        int dev;
        for (int n = 0; n < count; n++) begin
            dev = $urandom_range(1000) - 500;
            hw = (bool_near && $urandom_range(3) != 0)
                 ? 16'((int'(trim_xyz1) + dev) << 2) : 16'($urandom);
            send_burst(16'($urandom), 16'($urandom), 16'($urandom), hw, 1'b0, '0);
        end
    endtask

    typedef struct {
        logic [15:0] xw, yw, zw, hw;
        bit          typed;
        logic [74:0] want;
    } t_burst_row;

    // With reset trims every axis is invalid; the rest are predicted.
    t_burst_row burst_table[16] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 75'd0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 75'd0},
        '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 75'd0},
        '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 1'b1, 75'd0},
        '{16'h0000, 16'h0000, 16'h0000, 16'h6E34, 1'b0, 75'd0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6E34, 1'b0, 75'd0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h6E34, 1'b0, 75'd0},
        '{16'h8008, 16'h8009, 16'h8002, 16'h6E34, 1'b0, 75'd0},
        '{16'hFFFF, 16'hFFF8, 16'hFFFE, 16'h6E37, 1'b0, 75'd0},
        '{16'h0008, 16'h0001, 16'h0003, 16'h0004, 1'b0, 75'd0},
        '{16'h1230, 16'hEDC8, 16'h4000, 16'hFFFF, 1'b0, 75'd0},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 75'd0},
        '{16'h1111, 16'h2222, 16'h3333, 16'h0000, 1'b0, 75'd0},
        '{16'h1111, 16'h2222, 16'h3333, 16'h0003, 1'b0, 75'd0},
        '{16'hF000, 16'h0FF0, 16'hC000, 16'h0005, 1'b0, 75'd0},
        '{16'h0400, 16'hFC00, 16'h3FFE, 16'h8000, 1'b0, 75'd0}
    };

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            i_m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        logic [74:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (field_q.size() == 0) begin
                $error("result transfer with nothing expected: %h %b", o_m_tdata, o_m_tuser);
                failed = 1'b1;
            end else begin
                want = field_q.pop_front();
                if (o_m_tdata[23:0] !== want[23:0]) begin
                    $error("x_field: expected %h, got %h", want[23:0], o_m_tdata[23:0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[47:24] !== want[47:24]) begin
                    $error("y_field: expected %h, got %h", want[47:24], o_m_tdata[47:24]);
                    failed = 1'b1;
                end
                if (o_m_tdata[71:48] !== want[71:48]) begin
                    $error("z_field: expected %h, got %h", want[71:48], o_m_tdata[71:48]);
                    failed = 1'b1;
                end
                if (o_m_tuser[0] !== want[72]) begin
                    $error("x_valid: expected %b, got %b", want[72], o_m_tuser[0]);
                    failed = 1'b1;
                end
                if (o_m_tuser[1] !== want[73]) begin
                    $error("y_valid: expected %b, got %b", want[73], o_m_tuser[1]);
                    failed = 1'b1;
                end
                if (o_m_tuser[2] !== want[74]) begin
                    $error("z_valid: expected %b, got %b", want[74], o_m_tuser[2]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        trim_xy = '0;
        {trim_z1, trim_z2, trim_z3, trim_z4} = '0;
        trim_xyz1 = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed rows: first under reset trims, then under realistic trims.
        for (int i = 0; i < 4; i++)
            send_burst(burst_table[i].xw, burst_table[i].yw, burst_table[i].zw,
                       burst_table[i].hw, burst_table[i].typed, burst_table[i].want);
        i_s_tvalid <= 1'b0;
        drain_results();
        load_trims({8'd29, 8'hFD, 8'd26, 8'd26, 8'h03, 8'hFE}, 16'd24747, 16'd763,
                   16'hFFF6, 16'd12, 15'd7053);
        foreach (burst_table[i])
            send_burst(burst_table[i].xw, burst_table[i].yw, burst_table[i].zw,
                       burst_table[i].hw, 1'b0, '0);
        i_s_tvalid <= 1'b0;
        drain_results();

        // Zero Z denominator at r = 1, then zero Z trims.
        load_trims(48'h1D_00_1A_1A_00_00, 16'h8000, 16'hFFFF, 16'd0, 16'd0, 15'd100);
        for (int h = 4; h < 8; h++)
            send_burst(16'h0100, 16'hFF00, 16'h0200, 16'(h), 1'b0, '0);
        i_s_tvalid <= 1'b0;
        drain_results();
        write_trim(CFG_TRIM_Z1, 48'd0);
        send_burst(16'h0100, 16'hFF00, 16'h0200, 16'h1000, 1'b0, '0);
        i_s_tvalid <= 1'b0;
        drain_results();
        load_trims(48'hFF_7F_7F_7F_7F_7F, 16'h1234, 16'h0000, 16'h7FFF, 16'h8000, 15'h7FFF);
        send_burst(16'h7FFF, 16'h8008, 16'h3FFE, 16'hFFFF, 1'b0, '0);
        i_s_tvalid <= 1'b0;
        drain_results();

        // Random phases over varied trims, with pressure in some of them.
        for (int phase = 0; phase < 8; phase++) begin
            random_trims(phase % 4);
            quiet = (phase == 5);
            if (phase == 2) hold_req = 1'b1;
            random_bursts(90, phase % 4 == 0);
            if (phase == 3) begin
                i_s_tvalid <= 1'b0;
                while (field_q.size() != 0) @(posedge i_clk);
            end
            random_bursts(90, phase % 4 != 1);
            i_s_tvalid <= 1'b0;
            quiet = 1'b0;
            drain_results();
        end

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/mtc_pkg.sv
hdl/mtc_front.sv
hdl/mtc_queue.sv
hdl/mtc_divider.sv
hdl/mtc_back.sv
hdl/magnetometer_trim_compensation_unit.sv
test/magnetometer_trim_compensation_unit_tb.sv
